// ===== design/rmd_pkg.sv =====
// rmd_pkg: types, constants and lookup functions for the rotation matrix block
// holds the angle reduction constants, the cordic arctangent table and q1.15 rounding
// depends on nothing; used by rotation_matrix_from_degrees_top
package rmd_pkg;

  // widths of the fixed fields
  localparam int unsigned AngleW = 24;
  localparam int unsigned EntryW = 16;

  // angle reduction: offset by a whole number of turns so the sum is positive
  localparam int unsigned RedW = 25;
  localparam logic [RedW-1:0] ANGLE_OFFSET = 25'd8432640;  // 183 full turns of 46080
  // floor(a / 45) = (a * RECIP_45) >> DIV_SHIFT, exact for a < 2^25
  localparam logic [RedW-1:0] RECIP_45 = 25'd23860930;
  localparam int unsigned DivShift = 30;
  localparam int unsigned ProdW = 2 * RedW;
  // one full turn is 1024 steps of 45 units; the turn index sits in 10 bits
  localparam int unsigned TurnW = 10;
  localparam int unsigned RemW = 6;
  localparam logic [RemW-1:0] REM_LIMIT = 6'd45;
  localparam int unsigned FracW = 22;

  // cordic datapath, q2.30 for x and y, binary angle for z
  localparam int unsigned XyW = 32;
  localparam int unsigned ZW = 32;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned AtanIdxW = 5;
  localparam logic signed [XyW-1:0] GAIN_Q30 = 32'sd652032874;

  typedef logic signed [EntryW-1:0] q15_t;
  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [XyW-1:0] xy_t;
  typedef logic signed [ZW-1:0] zang_t;

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic [29:0] atan_ba(input logic [AtanIdxW-1:0] idx);
    logic [29:0] val;
    unique case (idx)
      5'd0:  val = 30'd536870912;
      5'd1:  val = 30'd316933406;
      5'd2:  val = 30'd167458907;
      5'd3:  val = 30'd85004756;
      5'd4:  val = 30'd42667331;
      5'd5:  val = 30'd21354465;
      5'd6:  val = 30'd10679838;
      5'd7:  val = 30'd5340245;
      5'd8:  val = 30'd2670163;
      5'd9:  val = 30'd1335087;
      5'd10: val = 30'd667544;
      5'd11: val = 30'd333772;
      5'd12: val = 30'd166886;
      5'd13: val = 30'd83443;
      5'd14: val = 30'd41722;
      5'd15: val = 30'd20861;
      5'd16: val = 30'd10430;
      5'd17: val = 30'd5215;
      5'd18: val = 30'd2608;
      5'd19: val = 30'd1304;
      5'd20: val = 30'd652;
      5'd21: val = 30'd326;
      5'd22: val = 30'd163;
      5'd23: val = 30'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

  // floor((v * 2^22 + 22) / 45), the low bits of the binary angle
  function automatic logic [FracW-1:0] frac_ba(input logic [RemW-1:0] v);
    logic [FracW-1:0] val;
    unique case (v)
      6'd0:  val = 22'd0;
      6'd1:  val = 22'd93207;
      6'd2:  val = 22'd186414;
      6'd3:  val = 22'd279620;
      6'd4:  val = 22'd372827;
      6'd5:  val = 22'd466034;
      6'd6:  val = 22'd559241;
      6'd7:  val = 22'd652447;
      6'd8:  val = 22'd745654;
      6'd9:  val = 22'd838861;
      6'd10: val = 22'd932068;
      6'd11: val = 22'd1025274;
      6'd12: val = 22'd1118481;
      6'd13: val = 22'd1211688;
      6'd14: val = 22'd1304895;
      6'd15: val = 22'd1398101;
      6'd16: val = 22'd1491308;
      6'd17: val = 22'd1584515;
      6'd18: val = 22'd1677722;
      6'd19: val = 22'd1770928;
      6'd20: val = 22'd1864135;
      6'd21: val = 22'd1957342;
      6'd22: val = 22'd2050549;
      6'd23: val = 22'd2143755;
      6'd24: val = 22'd2236962;
      6'd25: val = 22'd2330169;
      6'd26: val = 22'd2423376;
      6'd27: val = 22'd2516582;
      6'd28: val = 22'd2609789;
      6'd29: val = 22'd2702996;
      6'd30: val = 22'd2796203;
      6'd31: val = 22'd2889409;
      6'd32: val = 22'd2982616;
      6'd33: val = 22'd3075823;
      6'd34: val = 22'd3169030;
      6'd35: val = 22'd3262236;
      6'd36: val = 22'd3355443;
      6'd37: val = 22'd3448650;
      6'd38: val = 22'd3541857;
      6'd39: val = 22'd3635063;
      6'd40: val = 22'd3728270;
      6'd41: val = 22'd3821477;
      6'd42: val = 22'd3914684;
      6'd43: val = 22'd4007890;
      6'd44: val = 22'd4101097;
      default: val = '0;
    endcase
    return val;
  endfunction

  // q2.30 to q1.15: add half an lsb, floor shift, saturate
  function automatic q15_t to_q15(input logic signed [XyW+1:0] v);
    logic signed [XyW+1:0] sum;
    logic signed [XyW-14:0] rnd;
    q15_t res;
    sum = v + 34'sd16384;
    rnd = (XyW - 13)'(sum >>> 15);
    if (rnd > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (rnd < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = EntryW'(rnd);
    end
    return res;
  endfunction

endpackage

// ===== design/rotation_matrix_from_degrees_top.sv =====
// rotation_matrix_from_degrees_top: pipelined cordic that turns an angle into a 2d rotation matrix
// angle reduction, CORDIC_STEPS rotation stages and q1.15 output rounding
// depends on rmd_pkg
//
// usage
//   input channel: drive angle_deg_i (signed, 1/128 degree per lsb) and raise start_i;
//   the transfer happens at the rising edge where start_i is high and busy_o is low.
//   busy_o stays low, so a new angle can be given on every cycle.
//   output channel: valid_o is high for exactly one cycle with the four matrix entries
//   [cos -sin; sin cos] in signed q1.15; the transfer happens at the edge ending that cycle.
//   the receiver cannot stall, so results never wait and never back up the pipe.
// throughput and pipeline
//   one angle per cycle. between the accepting edge and the result strobe lie one input
//   register, one stage for the multiply by 1/45, one stage for the binary angle and
//   quadrant fold, one stage per cordic iteration and one for rounding and saturation.
// reset
//   rst_ni clears every valid bit at once; angles in flight are dropped and no strobe
//   follows until a new angle enters. the datapath registers are not reset.
module rotation_matrix_from_degrees_top #(
  parameter int unsigned CORDIC_STEPS = 16  // 8 to 24 iterations
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rmd_pkg::angle_t angle_deg_i,
  output logic          valid_o,
  output rmd_pkg::q15_t entry_row0_col0_o,
  output rmd_pkg::q15_t entry_row0_col1_o,
  output rmd_pkg::q15_t entry_row1_col0_o,
  output rmd_pkg::q15_t entry_row1_col1_o
);
  import rmd_pkg::*;

  // edges from the accepting edge to the edge that takes the result
  localparam int unsigned Latency = CORDIC_STEPS + 4;

  // the pipe never stalls
  assign busy_o = 1'b0;

  logic in_fire;
  assign in_fire = start_i & ~busy_o;

  // ---------------------------------------------------------------------------
  // stage 0: shift the angle by a whole number of turns so it is never negative
  // ---------------------------------------------------------------------------
  logic [RedW-1:0] ang_pos_d, ang_pos_q;
  logic            vld0_q;

  assign ang_pos_d = {angle_deg_i[AngleW-1], angle_deg_i} + ANGLE_OFFSET;

  // ---------------------------------------------------------------------------
  // stage 1: w = floor(a / 45) by reciprocal multiply; a full turn is 1024 * 45,
  // so w mod 1024 is the coarse position in the turn and a - 45w the remainder
  // ---------------------------------------------------------------------------
  logic [ProdW-1:0] recip_prod;
  logic [TurnW-1:0] turn_d, turn_q;
  logic [RemW-1:0]  ang_lo_q;
  logic             vld1_q;

  assign recip_prod = ang_pos_q * RECIP_45;
  assign turn_d     = recip_prod[DivShift +: TurnW];

  // ---------------------------------------------------------------------------
  // stage 2: binary angle (2^32 per turn) and fold into -90..+90 degrees
  // ---------------------------------------------------------------------------
  logic [2*RemW-1:0] w_times_45;
  logic [RemW-1:0]   frac_idx;
  logic [ZW-1:0]     bin_ang;
  logic              flip_d, flip_q;
  zang_t             z_d, z_q;
  logic              vld2_q;

  // only the low bits of 45w matter since the remainder stays below 45
  assign w_times_45 = {{RemW{1'b0}}, turn_q[RemW-1:0]} * {{RemW{1'b0}}, REM_LIMIT};
  assign frac_idx   = ang_lo_q - w_times_45[RemW-1:0];
  assign bin_ang    = {turn_q, frac_ba(frac_idx)};
  // second or third quadrant: rotate by half a turn and negate the results
  assign flip_d     = bin_ang[ZW-1] ^ bin_ang[ZW-2];
  assign z_d        = zang_t'({bin_ang[ZW-1] ^ flip_d, bin_ang[ZW-2:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld0_q <= in_fire;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_pos_q <= ang_pos_d;
    turn_q    <= turn_d;
    ang_lo_q  <= ang_pos_q[RemW-1:0];
    flip_q    <= flip_d;
    z_q       <= z_d;
  end

  // ---------------------------------------------------------------------------
  // cordic rotation stages, one iteration per register stage
  // ---------------------------------------------------------------------------
  xy_t   x_q    [CORDIC_STEPS];
  xy_t   y_q    [CORDIC_STEPS];
  zang_t zs_q   [CORDIC_STEPS];
  logic  fl_q   [CORDIC_STEPS];
  logic  vld_s_q[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    xy_t   x_in, y_in, dx, dy;
    zang_t z_in, dz;
    logic  fl_in, vld_in;

    if (i == 0) begin : g_first
      // x starts at the cordic gain, y at zero
      assign x_in   = GAIN_Q30;
      assign y_in   = '0;
      assign z_in   = z_q;
      assign fl_in  = flip_q;
      assign vld_in = vld2_q;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = zs_q[i-1];
      assign fl_in  = fl_q[i-1];
      assign vld_in = vld_s_q[i-1];
    end

    // arithmetic shifts floor toward minus infinity
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign dz = zang_t'({2'b00, atan_ba(AtanIdxW'(i))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s_q[i] <= 1'b0;
      end else begin
        vld_s_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      fl_q[i] <= fl_in;
      if (!z_in[ZW-1]) begin
        x_q[i]  <= x_in - dx;
        y_q[i]  <= y_in + dy;
        zs_q[i] <= z_in - dz;
      end else begin
        x_q[i]  <= x_in + dx;
        y_q[i]  <= y_in - dy;
        zs_q[i] <= z_in + dz;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: undo the fold, round to q1.15 and saturate
  // ---------------------------------------------------------------------------
  localparam int unsigned WideW = XyW + 2;
  logic signed [WideW-1:0] x_wide, y_wide, x_fix, y_fix;
  q15_t cos_d, sin_d, nsin_d;
  q15_t cos_q, sin_q, nsin_q;
  logic vld_out_q;
  logic signed [EntryW:0] sine_sum;

  assign x_wide = WideW'(x_q[CORDIC_STEPS-1]);
  assign y_wide = WideW'(y_q[CORDIC_STEPS-1]);
  assign x_fix  = fl_q[CORDIC_STEPS-1] ? -x_wide : x_wide;
  assign y_fix  = fl_q[CORDIC_STEPS-1] ? -y_wide : y_wide;
  assign cos_d  = to_q15(x_fix);
  assign sin_d  = to_q15(y_fix);
  // negated from the unsaturated sine, so a sine of -1 gives +32767
  assign nsin_d = to_q15(-y_fix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_s_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= cos_d;
    sin_q  <= sin_d;
    nsin_q <= nsin_d;
  end

  assign valid_o           = vld_out_q;
  assign entry_row0_col0_o = cos_q;
  assign entry_row0_col1_o = nsin_q;
  assign entry_row1_col0_o = sin_q;
  assign entry_row1_col1_o = cos_q;

  // sine plus negated sine, off zero only by a rounding tie or saturation
  assign sine_sum = {sin_q[EntryW-1], sin_q} + {nsin_q[EntryW-1], nsin_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every accepted angle yields a strobe after the full pipe depth
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##Latency valid_o)
    else $error("accepted angle produced no result");

  // no strobe without an accepted angle at the pipe depth before
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_fire, Latency))
    else $error("result strobe without an accepted angle");

  // the reciprocal divide must leave a remainder below 45
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q |-> (frac_idx < REM_LIMIT))
    else $error("angle remainder out of range");

  // negated sine stays within one lsb of minus the sine
  a_neg_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((sine_sum >= -17'sd1) && (sine_sum <= 17'sd1)))
    else $error("negated sine does not match sine");

endmodule

// ===== tb/sv/rotation_matrix_checker.sv =====
`timescale 1ns / 1ps
// rotation_matrix_checker: predicts the cos/-sin/sin/cos entries for every accepted angle
// and compares them with each result strobe of the rotation matrix block
// depends on rmd_pkg for the angle and entry types
module rotation_matrix_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  rmd_pkg::angle_t angle_deg_i,
  input  logic            valid_i,
  input  rmd_pkg::q15_t   entry_row0_col0_i,
  input  rmd_pkg::q15_t   entry_row0_col1_i,
  input  rmd_pkg::q15_t   entry_row1_col0_i,
  input  rmd_pkg::q15_t   entry_row1_col1_i,
  output int              mismatch_count_o,
  output int              pending_count_o
);

  localparam longint FullTurnUnits = 46080;
  localparam longint CordicGainQ30 = 652032874;
  localparam int     ArctanLen = 24;

  // arctangent of 2^-i, binary angle units (2^32 per turn)
  localparam longint ArctanBa [ArctanLen] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    rmd_pkg::angle_t angle;
    rmd_pkg::q15_t   cos_a;
    rmd_pkg::q15_t   neg_sin_a;
    rmd_pkg::q15_t   sin_a;
    rmd_pkg::q15_t   cos_b;
  } rot_matrix_t;

  rot_matrix_t matrix_q[$];
  int          mismatches;
  int          pending;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  function automatic rmd_pkg::q15_t round_sat_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return rmd_pkg::q15_t'(r);
  endfunction

  function automatic rot_matrix_t predict_rotation(input rmd_pkg::angle_t ang);
    longint      reduced;
    longint      z;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] bin_angle;
    logic [31:0] folded;
    logic        flip;
    rot_matrix_t m;
    reduced = longint'(ang) % FullTurnUnits;
    if (reduced < 0) reduced += FullTurnUnits;
    bin_angle = 32'(((reduced << 22) + 22) / 45);
    // fold the half turn around 180 degrees onto -90..+90, negate afterwards
    folded = bin_angle + 32'h4000_0000;
    flip = folded[31];
    if (flip) bin_angle = bin_angle + 32'h8000_0000;
    z = bin_angle[31] ? longint'(bin_angle) - 64'sh1_0000_0000 : longint'(bin_angle);
    x = CordicGainQ30;
    y = 0;
    for (int i = 0; i < int'(CORDIC_STEPS) && i < ArctanLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ArctanBa[i];
      end else begin
        x += dx;
        y -= dy;
        z += ArctanBa[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    m.angle     = ang;
    m.cos_a     = round_sat_q15(x);
    m.neg_sin_a = round_sat_q15(-y);
    m.sin_a     = round_sat_q15(y);
    m.cos_b     = m.cos_a;
    return m;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk_i) begin : watch_channels
    rot_matrix_t want;
    if (rst_ni) begin
      if (valid_i) begin
        if (matrix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no angle pending: %0d %0d %0d %0d", $realtime,
                     entry_row0_col0_i, entry_row0_col1_i, entry_row1_col0_i,
                     entry_row1_col1_i);
        end else begin
          want = matrix_q.pop_front();
          pending--;
          if (entry_row0_col0_i !== want.cos_a || entry_row0_col1_i !== want.neg_sin_a ||
              entry_row1_col0_i !== want.sin_a || entry_row1_col1_i !== want.cos_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: angle %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       $realtime, want.angle, want.cos_a, want.neg_sin_a, want.sin_a,
                       want.cos_b, entry_row0_col0_i, entry_row0_col1_i,
                       entry_row1_col0_i, entry_row1_col1_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        matrix_q.push_back(predict_rotation(angle_deg_i));
        pending++;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives angles into the rotation matrix block and gives the verdict
// depends on rmd_pkg, rotation_matrix_from_degrees_top and rotation_matrix_checker
module testbench;

  localparam int unsigned CordicSteps = 16;
  // idle time after the final drain, longer than the pipe, for stray strobes to show up
  localparam int DrainCycles = 2 * (CordicSteps + 3) + 8;
  // ~825 transfers, each with at most the longest idle gap, plus pipeline drains: far below this
  localparam int CycleLimit = 400000;
  localparam int RandomItems = 800;
  localparam int DirectedLen = 24;

  // directed angles, 1/128 degree units: quadrant edges, full turns, field extremes
  localparam int DirectedAngles [DirectedLen] = '{
    0, 11520, 23040, 34560, 46080, -11520, -23040, -34560, -46080,
    1, -1, 11519, 11521, 23039, 23041, 34559, 34561, 46079,
    5760, 3840, 7680, 8388607, -8388608, 8386560
  };

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  rmd_pkg::angle_t angle_deg_i;
  logic            valid_o;
  rmd_pkg::q15_t   entry_row0_col0_o;
  rmd_pkg::q15_t   entry_row0_col1_o;
  rmd_pkg::q15_t   entry_row1_col0_o;
  rmd_pkg::q15_t   entry_row1_col1_o;
  int              mismatch_count;
  int              pending_count;
  int              cycle_count;

  rotation_matrix_from_degrees_top #(
    .CORDIC_STEPS(CordicSteps)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .angle_deg_i      (angle_deg_i),
    .valid_o          (valid_o),
    .entry_row0_col0_o(entry_row0_col0_o),
    .entry_row0_col1_o(entry_row0_col1_o),
    .entry_row1_col0_o(entry_row1_col0_o),
    .entry_row1_col1_o(entry_row1_col1_o)
  );

  // the checker sees the same pins as the block and keeps the expected matrices
  rotation_matrix_checker #(
    .CORDIC_STEPS(CordicSteps)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .angle_deg_i      (angle_deg_i),
    .valid_i          (valid_o),
    .entry_row0_col0_i(entry_row0_col0_o),
    .entry_row0_col1_i(entry_row0_col1_o),
    .entry_row1_col0_i(entry_row1_col0_o),
    .entry_row1_col1_i(entry_row1_col1_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung pipe or a lost result ends the run here
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[rotation_matrix_from_degrees_top] ERROR");
      $finish;
    end
  end

  // idle length before the next angle: mostly none or short, now and then long
  function automatic int pick_gap(input bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // random angle: the whole field, near quadrant edges of any turn, or a few turns either way
  function automatic rmd_pkg::angle_t pick_angle();
    int mode;
    int turns;
    mode = $urandom_range(0, 3);
    if (mode <= 1) return rmd_pkg::angle_t'($urandom);
    if (mode == 2) begin
      turns = int'($urandom_range(0, 1456)) - 728;
      return rmd_pkg::angle_t'(turns * 11520 + int'($urandom_range(0, 4)) - 2);
    end
    return rmd_pkg::angle_t'(int'($urandom_range(0, 184319)) - 92160);
  endfunction

  // one transfer: hold start until an edge with busy low, then idle for gap cycles
  task automatic send_angle(input rmd_pkg::angle_t ang, input int gap);
    start_i     <= 1'b1;
    angle_deg_i <= ang;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    if (gap > 0) begin
      start_i     <= 1'b0;
      // junk on the angle pins while start is low, must be ignored
      angle_deg_i <= rmd_pkg::angle_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off the sender until every expected matrix has come back
  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    bit no_idle;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    angle_deg_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, back to back first, then with random idling
    for (int i = 0; i < DirectedLen; i++) begin
      send_angle(rmd_pkg::angle_t'(DirectedAngles[i]), (i < 12) ? 0 : pick_gap(1'b0));
    end
    drain_results();

    // random part; every 100 transfers starts with a stretch of 30 without idling
    for (int i = 0; i < RandomItems; i++) begin
      no_idle = (i % 100) < 30;
      send_angle(pick_angle(), pick_gap(no_idle));
      if (i == RandomItems / 2) drain_results();
    end
    start_i <= 1'b0;

    // wait for the pipe to empty, then give stray strobes a chance to show up
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[rotation_matrix_from_degrees_top] OK");
    end else begin
      $display("[rotation_matrix_from_degrees_top] ERROR");
    end
    $finish;
  end

endmodule
